### sv/lkcx_pkg.sv
// Package for the keyed keystream XOR cipher: opcodes, header positions,
// generator constants and the command and status bundles between the
// controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkcx_pkg;

    localparam int KEYSTREAM_BYTES_DEF = 520;
    localparam int KS_WORDS_DEF        = (KEYSTREAM_BYTES_DEF + 1) / 2;

    // Item opcodes.
    localparam logic [1:0] OP_SET_KEY = 2'd0;
    localparam logic [1:0] OP_ENCRYPT = 2'd1;
    localparam logic [1:0] OP_DECRYPT = 2'd2;

    // Packet header positions.
    localparam logic [1:0] HDR_FIRST  = 2'd0;
    localparam logic [1:0] HDR_SECOND = 2'd1;
    localparam logic [1:0] HDR_BODY   = 2'd2;

    // Generator constants. LCG_RECIP / 2^48 approximates 1 / LCG_Q from above.
    localparam logic [31:0] LCG_RECIP = 32'h834E0B5F;
    localparam logic [16:0] LCG_Q     = 17'd127773;
    localparam logic [14:0] LCG_A     = 15'd16807;
    localparam logic [11:0] LCG_R     = 12'd2836;
    localparam logic [6:0]  LCG_INC   = 7'd123;
    localparam logic [31:0] LCG_FIX   = 32'h7FFFFFFF;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic step_abs;
        logic step_mulq;
        logic step_rem;
        logic step_corr;
        logic step_mul2;
        logic step_sum;
        logic step_write;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_needed;
        logic fill_last;
    } t_status;

endpackage

`default_nettype wire

### sv/lkcx_if.sv
// Valid/ready channel interfaces for the cipher's input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface lkcx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] new_key;
    logic [7:0]  data_in;
    logic        start_of_packet;

    modport source (output valid, output opcode, output new_key, output data_in,
                    output start_of_packet, input ready);
    modport sink   (input valid, input opcode, input new_key, input data_in,
                    input start_of_packet, output ready);
endinterface

interface lkcx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       key_accepted;
    logic       keystream_overrun;

    modport source (output valid, output data_out, output key_accepted,
                    output keystream_overrun, input ready);
    modport sink   (input valid, input data_out, input key_accepted,
                    input keystream_overrun, output ready);
endinterface

`default_nettype wire

### sv/lkcx_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on lkcx_pkg for its default depth.
`timescale 1ns / 1ps
`default_nettype none

module lkcx_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = lkcx_pkg::KS_WORDS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/lkcx_ctrl.sv
// Controller state machine of the cipher: input handshake, item execution
// and the seven-step keystream generator sequence. Depends on lkcx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkcx_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lkcx_pkg::t_status i_status,
    output lkcx_pkg::t_cmd         o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EXEC  = 9'b000000010,
        ST_ABS   = 9'b000000100,
        ST_MULQ  = 9'b000001000,
        ST_REM   = 9'b000010000,
        ST_CORR  = 9'b000100000,
        ST_MUL2  = 9'b001000000,
        ST_SUM   = 9'b010000000,
        ST_WRITE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result can only be produced once the output register is free.
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.fill_needed ? ST_ABS : ST_IDLE;
                end
            end
            ST_ABS: begin
                o_cmd.step_abs = 1'b1;
                n_state        = ST_MULQ;
            end
            ST_MULQ: begin
                o_cmd.step_mulq = 1'b1;
                n_state         = ST_REM;
            end
            ST_REM: begin
                o_cmd.step_rem = 1'b1;
                n_state        = ST_CORR;
            end
            ST_CORR: begin
                o_cmd.step_corr = 1'b1;
                n_state         = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.step_mul2 = 1'b1;
                n_state         = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.step_sum = 1'b1;
                n_state        = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.step_write = 1'b1;
                n_state          = i_status.fill_last ? ST_IDLE : ST_ABS;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

### sv/lkcx_datapath.sv
// Datapath of the cipher: key and packet state, the byte transform, the
// keystream generator arithmetic, the keystream RAM and the result register.
// Depends on lkcx_pkg and lkcx_ram.
`timescale 1ns / 1ps
`default_nettype none

module lkcx_datapath #(
    parameter int KEYSTREAM_BYTES = lkcx_pkg::KEYSTREAM_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [31:0]       i_cfg_wr_data,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [31:0]       i_new_key,
    input  wire logic [7:0]        i_data_in,
    input  wire logic              i_start_of_packet,
    input  wire lkcx_pkg::t_cmd    i_cmd,
    output lkcx_pkg::t_status      o_status,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_data_out,
    output logic                   o_key_accepted,
    output logic                   o_keystream_overrun
);

    localparam int KS_WORDS = (KEYSTREAM_BYTES + 1) / 2;
    localparam int AW       = (KS_WORDS > 1) ? $clog2(KS_WORDS) : 1;
    localparam int CW       = $clog2(KEYSTREAM_BYTES + 1);

    // Configuration and key/packet state.
    logic [31:0]   r_local_key;
    logic [31:0]   r_sess_key, n_sess_key;
    logic [31:0]   r_chain, n_chain;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_hdr_pos, n_hdr_pos;
    logic          r_first_zero, n_first_zero;

    // Latched input item.
    logic [1:0]    r_op;
    logic [31:0]   r_key;
    logic [7:0]    r_data;
    logic          r_sop;

    // Result register.
    logic          r_out_valid;
    logic [7:0]    r_data_out, n_data_out;
    logic          r_key_accepted, n_key_accepted;
    logic          r_overrun, n_overrun;

    // Keystream generator.
    logic [31:0]        r_lcg_w;
    logic [AW-1:0]      r_fill_addr;
    logic [31:0]        r_absk;
    logic               r_kneg;
    logic [63:0]        r_up;
    logic [16:0]        r_t;
    logic [17:0]        r_rem_raw;
    logic [16:0]        r_rem;
    logic [30:0]        r_p1;
    logic signed [27:0] r_p2;
    logic [31:0]        r_sum;

    logic [15:0]        ks_word;
    logic               key_is_client;
    logic               key_ok;
    logic               fill_needed;
    logic [1:0]         hdr;
    logic [1:0]         lane;
    logic [7:0]         ks_byte;
    logic [7:0]         chain_byte;
    logic [7:0]         xor_byte;
    logic [7:0]         cipher_byte;

    logic [15:0]        q_est;
    logic               lo_nz;
    logic [16:0]        t_mag;
    logic [16:0]        n_t;
    logic [33:0]        q_prod;
    logic [17:0]        n_rem_raw;
    logic [16:0]        n_rem;
    logic [31:0]        p1_wide;
    logic signed [27:0] t_ext;
    logic signed [27:0] n_p2;
    logic [31:0]        p1_signed;
    logic [31:0]        n_sum;
    logic [31:0]        w_fix;

    // ---------------------------------------------------------------
    // Item execution
    // ---------------------------------------------------------------
    always_comb begin
        key_is_client = (r_key == r_local_key);
        key_ok        = (r_key == r_sess_key) || key_is_client
                        || (r_key == (32'd0 - r_local_key));
        fill_needed   = (r_op == lkcx_pkg::OP_SET_KEY) && key_ok && !key_is_client;

        hdr         = r_sop ? lkcx_pkg::HDR_FIRST : r_hdr_pos;
        lane        = r_count[1:0];
        ks_byte     = r_count[0] ? ks_word[15:8] : ks_word[7:0];
        chain_byte  = r_chain[{lane, 3'b000} +: 8];
        xor_byte    = r_data ^ ks_byte ^ chain_byte;
        cipher_byte = (r_op == lkcx_pkg::OP_ENCRYPT) ? xor_byte : r_data;

        n_sess_key     = r_sess_key;
        n_chain        = r_chain;
        n_count        = r_count;
        n_hdr_pos      = r_hdr_pos;
        n_first_zero   = r_first_zero;
        n_data_out     = 8'd0;
        n_key_accepted = 1'b0;
        n_overrun      = 1'b0;

        unique case (r_op) inside
            lkcx_pkg::OP_SET_KEY: begin
                n_key_accepted = key_ok;
                if (key_ok) begin
                    n_hdr_pos  = lkcx_pkg::HDR_FIRST;
                    n_sess_key = key_is_client ? 32'd0 : r_key;
                end
            end
            lkcx_pkg::OP_ENCRYPT, lkcx_pkg::OP_DECRYPT: begin
                n_data_out = r_data;
                if (hdr == lkcx_pkg::HDR_FIRST) begin
                    n_chain      = r_sess_key;
                    n_count      = '0;
                    n_first_zero = (r_data == 8'd0);
                    n_hdr_pos    = lkcx_pkg::HDR_SECOND;
                end else if (hdr == lkcx_pkg::HDR_SECOND && r_first_zero) begin
                    n_hdr_pos = lkcx_pkg::HDR_BODY;
                end else begin
                    n_hdr_pos = lkcx_pkg::HDR_BODY;
                    if (r_sess_key != 32'd0) begin
                        if (r_count >= CW'(KEYSTREAM_BYTES)) begin
                            n_overrun = 1'b1;
                        end else begin
                            n_data_out                    = xor_byte;
                            n_chain[{lane, 3'b000} +: 8] = cipher_byte;
                            n_count                       = r_count + CW'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_key  <= '0;
            r_sess_key   <= '0;
            r_chain      <= '0;
            r_count      <= '0;
            r_hdr_pos    <= lkcx_pkg::HDR_FIRST;
            r_first_zero <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_local_key <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_sess_key   <= n_sess_key;
                r_chain      <= n_chain;
                r_count      <= n_count;
                r_hdr_pos    <= n_hdr_pos;
                r_first_zero <= n_first_zero;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_opcode;
            r_key  <= i_new_key;
            r_data <= i_data_in;
            r_sop  <= i_start_of_packet;
        end
        if (i_cmd.exec) begin
            r_data_out     <= n_data_out;
            r_key_accepted <= n_key_accepted;
            r_overrun      <= n_overrun;
        end
    end

    // ---------------------------------------------------------------
    // Keystream generator: one Schrage step, commanded by the controller.
    // The quotient estimate from the reciprocal is never low, and for a
    // magnitude up to 2^31 its excess stays below one, so the registered
    // remainder only needs a single range check.
    // ---------------------------------------------------------------
    always_comb begin
        q_est     = r_up[63:48];
        lo_nz     = |r_up[47:0];
        // A negative seed rounds the shifted product toward minus infinity,
        // then takes one more off.
        t_mag     = {1'b0, q_est} + 17'(lo_nz) + 17'd1;
        n_t       = r_kneg ? (17'd0 - t_mag) : {1'b0, q_est};
        q_prod    = 34'(q_est) * 34'(lkcx_pkg::LCG_Q);
        n_rem_raw = 18'(34'(r_absk) - q_prod);
        n_rem     = (r_rem_raw >= 18'(lkcx_pkg::LCG_Q))
                    ? 17'(r_rem_raw - 18'(lkcx_pkg::LCG_Q)) : r_rem_raw[16:0];
        p1_wide   = 32'(r_rem) * 32'(lkcx_pkg::LCG_A);
        t_ext     = {{11{r_t[16]}}, r_t};
        n_p2      = t_ext * $signed(28'(lkcx_pkg::LCG_R));
        p1_signed = r_kneg ? (32'd0 - 32'(r_p1)) : 32'(r_p1);
        n_sum     = p1_signed - {{4{r_p2[27]}}, r_p2} + 32'(lkcx_pkg::LCG_INC);
        w_fix     = (r_sum == 32'd0 || r_sum[31]) ? (r_sum + lkcx_pkg::LCG_FIX) : r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && fill_needed) begin
            r_lcg_w     <= r_key;
            r_fill_addr <= '0;
        end
        if (i_cmd.step_abs) begin
            r_absk <= r_lcg_w[31] ? (32'd0 - r_lcg_w) : r_lcg_w;
            r_kneg <= r_lcg_w[31];
        end
        if (i_cmd.step_mulq) begin
            r_up <= 64'(r_absk) * 64'(lkcx_pkg::LCG_RECIP);
        end
        if (i_cmd.step_rem) begin
            r_t       <= n_t;
            r_rem_raw <= n_rem_raw;
        end
        if (i_cmd.step_corr) begin
            r_rem <= n_rem;
        end
        if (i_cmd.step_mul2) begin
            r_p1 <= p1_wide[30:0];
            r_p2 <= n_p2;
        end
        if (i_cmd.step_sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.step_write) begin
            r_lcg_w     <= w_fix;
            r_fill_addr <= r_fill_addr + AW'(1);
        end
    end

    // The read address follows the byte count, so the word for the next
    // body byte is already registered when that byte executes.
    lkcx_ram #(
        .WIDTH (16),
        .DEPTH (KS_WORDS)
    ) u_ks_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.step_write),
        .i_wr_addr (r_fill_addr),
        .i_wr_data (w_fix[15:0]),
        .i_rd_addr (r_count[AW:1]),
        .o_rd_data (ks_word)
    );

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.fill_needed = fill_needed;
    assign o_status.fill_last   = (r_fill_addr == AW'(KS_WORDS - 1));

    assign o_out_valid         = r_out_valid;
    assign o_data_out          = r_data_out;
    assign o_key_accepted      = r_key_accepted;
    assign o_keystream_overrun = r_overrun;

endmodule

`default_nettype wire

### sv/lcg_keystream_chained_xor_cipher.sv
// Keyed byte cipher with an LCG keystream and a chained XOR, top level.
// Depends on lkcx_pkg, lkcx_if, lkcx_ctrl, lkcx_datapath and lkcx_ram.
//
// Use: items enter on i_in (valid/ready) and each gives exactly one result
// on o_out (valid/ready). Opcode set-key offers a server key; encrypt and
// decrypt move one packet byte. The client key is written through
// i_cfg_wr_en / i_cfg_wr_data while no item is in flight.
// A byte item is latched in the idle state and executed in the execute state
// once the output register is free; the block takes no new item until the
// last one has executed. A set-key item accepted with a key other than the
// client key then fills the keystream RAM: one generator step (abs, reciprocal
// multiply, remainder, correction, two products, sum and write) per 16-bit
// word, and the input stays not ready until the fill is done.
// A new item is accepted while a result waits in the output register; it is
// held in execution until the receiver takes that result.
// Reset clears the keys, packet state, controller and output valid. The
// keystream RAM is not cleared: it is read only under a nonzero session key,
// which is only ever set by a fill.
`timescale 1ns / 1ps
`default_nettype none

module lcg_keystream_chained_xor_cipher #(
    parameter int KEYSTREAM_BYTES = lkcx_pkg::KEYSTREAM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lkcx_in_if.sink          i_in,
    lkcx_out_if.source       o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    lkcx_pkg::t_cmd    cmd;
    lkcx_pkg::t_status status;
    logic              in_ready;

    lkcx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lkcx_datapath #(
        .KEYSTREAM_BYTES (KEYSTREAM_BYTES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_opcode            (i_in.opcode),
        .i_new_key           (i_in.new_key),
        .i_data_in           (i_in.data_in),
        .i_start_of_packet   (i_in.start_of_packet),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_data_out          (o_out.data_out),
        .o_key_accepted      (o_out.key_accepted),
        .o_keystream_overrun (o_out.keystream_overrun)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

### sv/lkcx_checker.sv
// Port-level checker for the cipher top level and the bind that attaches it.
// Depends on lcg_keystream_chained_xor_cipher and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module lkcx_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_data_out,
    input wire logic       i_key_accepted,
    input wire logic       i_keystream_overrun
);

    // A stalled result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out)
            && $stable(i_key_accepted) && $stable(i_keystream_overrun))
        else $error("result changed while stalled");

    // Only set-key results accept keys and only byte results overrun.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_key_accepted && i_keystream_overrun))
        else $error("key_accepted and keystream_overrun both set");

    // An accepted key reports a zero data byte.
    a_key_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_accepted |-> i_data_out == 8'd0)
        else $error("set-key result carries data");

    // Each accepted transaction is executed before another one is taken.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind lcg_keystream_chained_xor_cipher lkcx_port_checker u_lkcx_port_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_data_out          (o_out.data_out),
    .i_key_accepted      (o_out.key_accepted),
    .i_keystream_overrun (o_out.keystream_overrun)
);

`default_nettype wire

### sim/lkcx_checker.sv
// Scoreboard for the keystream cipher testbench: watches the item and result
// channels and the client key port, predicts each result and compares fields.
// Depends on lkcx_pkg.
`timescale 1ns / 1ps

module lkcx_checker #(
    parameter int KS_BYTES = lkcx_pkg::KEYSTREAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_new_key,
    input  logic [7:0]  i_data_in,
    input  logic        i_sop,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_data_out,
    input  logic        i_key_accepted,
    input  logic        i_overrun,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_keys_applied,
    output int          o_overruns
);

    localparam int     KS_WORDS  = (KS_BYTES + 1) / 2;
    localparam longint GEN_RECIP = lkcx_pkg::LCG_RECIP;
    localparam longint GEN_Q     = lkcx_pkg::LCG_Q;
    localparam longint GEN_A     = lkcx_pkg::LCG_A;
    localparam longint GEN_R     = lkcx_pkg::LCG_R;
    localparam longint GEN_INC   = lkcx_pkg::LCG_INC;

    typedef struct packed {
        logic [7:0] data;
        logic       accepted;
        logic       overrun;
    } t_cipher_result;

    logic [31:0] local_key;
    logic [31:0] sess_key;
    logic [15:0] ks_words [KS_WORDS];
    logic [31:0] chain;
    int          cipher_count;
    logic [1:0]  hdr_pos;
    logic        first_zero;

    t_cipher_result expected_q [$];
    int n_fail = 0;
    int n_checked = 0;
    int n_keys = 0;
    int n_overruns = 0;
    int n_pending = 0;

    assign o_fail_count   = n_fail;
    assign o_pending      = n_pending;
    assign o_checked      = n_checked;
    assign o_keys_applied = n_keys;
    assign o_overruns     = n_overruns;

    // One generator step. The quotient by the divisor comes from a multiply by
    // a scaled reciprocal, rounded away from zero for negative products.
    function automatic logic [31:0] lcg_next(input logic [31:0] w);
        longint          k;
        longint          prod;
        longint          t;
        longint          r;
        longint unsigned mag;
        logic [31:0]     x;
        k = $signed(w);
        prod = k * GEN_RECIP;
        if (prod >= 0) begin
            t = prod >>> 48;
        end else begin
            mag = -prod;
            t = -longint'((mag + 64'hFFFF_FFFF_FFFF) >> 48);
        end
        if (t < 0) begin
            t = t - 1;
        end
        r = (k % GEN_Q) * GEN_A - t * GEN_R + GEN_INC;
        x = r[31:0];
        if (x == 32'd0 || x[31]) begin
            x = x + lkcx_pkg::LCG_FIX;
        end
        return x;
    endfunction

    function automatic void fill_keystream(input logic [31:0] seed);
        logic [31:0] w;
        w = seed;
        for (int i = 0; i < KS_WORDS; i++) begin
            w = lcg_next(w);
            ks_words[i] = w[15:0];
        end
    endfunction

    function automatic t_cipher_result predict_item(input logic [1:0] op,
                                                    input logic [31:0] key,
                                                    input logic [7:0] din,
                                                    input logic sop);
        t_cipher_result res;
        logic [7:0]     ks_byte;
        logic [7:0]     cipher;
        int             lane;
        res = '0;
        case (op)
            lkcx_pkg::OP_SET_KEY: begin
                if (key == sess_key || key == local_key || key == -local_key) begin
                    res.accepted = 1'b1;
                    n_keys++;
                    if (key == local_key) begin
                        sess_key = '0;
                        foreach (ks_words[j]) ks_words[j] = '0;
                    end else begin
                        sess_key = key;
                        fill_keystream(key);
                    end
                    hdr_pos = lkcx_pkg::HDR_FIRST;
                end
            end
            lkcx_pkg::OP_ENCRYPT, lkcx_pkg::OP_DECRYPT: begin
                if (sop) begin
                    hdr_pos = lkcx_pkg::HDR_FIRST;
                end
                res.data = din;
                if (hdr_pos == lkcx_pkg::HDR_FIRST) begin
                    chain = sess_key;
                    cipher_count = 0;
                    first_zero = (din == 8'h00);
                    hdr_pos = lkcx_pkg::HDR_SECOND;
                end else if (hdr_pos == lkcx_pkg::HDR_SECOND && first_zero) begin
                    hdr_pos = lkcx_pkg::HDR_BODY;
                end else begin
                    hdr_pos = lkcx_pkg::HDR_BODY;
                    if (sess_key != 0) begin
                        if (cipher_count >= KS_BYTES) begin
                            res.overrun = 1'b1;
                            n_overruns++;
                        end else begin
                            ks_byte = ks_words[cipher_count / 2] >> ((cipher_count % 2) * 8);
                            lane = cipher_count % 4;
                            res.data = din ^ ks_byte ^ chain[lane*8 +: 8];
                            // The chain always takes the ciphertext side of the byte.
                            cipher = (op == lkcx_pkg::OP_ENCRYPT) ? res.data : din;
                            chain[lane*8 +: 8] = cipher;
                            cipher_count++;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_fail++;
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $time, n_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_cipher_result want;
        if (!i_rst_n) begin
            local_key = '0;
            sess_key = '0;
            foreach (ks_words[j]) ks_words[j] = '0;
            chain = '0;
            cipher_count = 0;
            hdr_pos = lkcx_pkg::HDR_FIRST;
            first_zero = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                local_key = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(predict_item(i_opcode, i_new_key, i_data_in, i_sop));
            end
            if (i_out_valid && i_out_ready) begin
                n_checked++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result transaction with none expected", i_data_out, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_data_out !== want.data) begin
                        report_mismatch("data_out", i_data_out, want.data);
                    end
                    if (i_key_accepted !== want.accepted) begin
                        report_mismatch("key_accepted", i_key_accepted, want.accepted);
                    end
                    if (i_overrun !== want.overrun) begin
                        report_mismatch("keystream_overrun", i_overrun, want.overrun);
                    end
                end
            end
        end
        n_pending <= expected_q.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the keystream cipher: clock, reset, directed and random
// stimulus on both channels, client key writes and the final verdict.
// Depends on lkcx_pkg, lkcx_if, the cipher RTL and lkcx_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET     = 1150;
    localparam int LONG_PACKET     = lkcx_pkg::KEYSTREAM_BYTES_DEF + 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    lkcx_in_if  in_ch ();
    lkcx_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int keys_applied;
    int overruns;
    int items_sent = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit rx_hold_req = 1'b0;
    logic [31:0] client_shadow = '0;
    logic [31:0] session_shadow = '0;

    always #6 i_clk = ~i_clk;

    lcg_keystream_chained_xor_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    lkcx_checker #(
        .KS_BYTES (lkcx_pkg::KEYSTREAM_BYTES_DEF)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_opcode       (in_ch.opcode),
        .i_new_key      (in_ch.new_key),
        .i_data_in      (in_ch.data_in),
        .i_sop          (in_ch.start_of_packet),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_data_out     (out_ch.data_out),
        .i_key_accepted (out_ch.key_accepted),
        .i_overrun      (out_ch.keystream_overrun),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_keys_applied (keys_applied),
        .o_overruns     (overruns)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Valid stays high across back-to-back transactions; it only drops for a gap.
    task automatic send_item(input logic [1:0] op, input logic [31:0] key,
                             input logic [7:0] din, input logic sop);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.new_key <= key;
        in_ch.data_in <= din;
        in_ch.start_of_packet <= sop;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (op == lkcx_pkg::OP_SET_KEY &&
            (key == session_shadow || key == client_shadow || key == -client_shadow)) begin
            session_shadow = (key == client_shadow) ? '0 : key;
        end
    endtask

    // The client key only changes with nothing in flight and the keystream fill done.
    task automatic write_client_key(input logic [31:0] value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        client_shadow = value;
        cfg_writes++;
    endtask

    initial begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [31:0] key;
        logic [1:0]  op;
        logic [1:0]  byte_op;
        logic [7:0]  din;
        int          n_packets;
        int          len;
        int          phase;
        bit          long_done;
        in_ch.valid = 1'b0;
        in_ch.opcode = lkcx_pkg::OP_SET_KEY;
        in_ch.new_key = '0;
        in_ch.data_in = '0;
        in_ch.start_of_packet = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_rst_n = 1'b0;
        long_done = 1'b0;
        phase = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encryption is off after reset, and the first byte starts a packet
        // even without the start mark.
        send_item(lkcx_pkg::OP_ENCRYPT, $urandom, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, $urandom, 8'hFF, 1'b0);
        send_item(lkcx_pkg::OP_DECRYPT, $urandom, 8'h5A, 1'b0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_item(lkcx_pkg::OP_SET_KEY, 32'h0000_0000, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_SET_KEY, 32'h1234_5678, 8'h00, 1'b0);

        // Negated client key with the sign bit set, then packets through both headers.
        write_client_key(32'h0000_0001);
        send_item(lkcx_pkg::OP_SET_KEY, 32'hFFFF_FFFF, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h00, 1'b1);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'hFF, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'hFF, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h80, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h01, 1'b0);
        send_item(lkcx_pkg::OP_DECRYPT, '0, 8'h01, 1'b1);
        send_item(lkcx_pkg::OP_DECRYPT, '0, 8'hFF, 1'b0);
        send_item(lkcx_pkg::OP_DECRYPT, '0, 8'h7F, 1'b0);
        send_item(lkcx_pkg::OP_SET_KEY, 32'hFFFF_FFFF, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_SET_KEY, 32'h0000_0001, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h42, 1'b1);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h42, 1'b0);

        // A client key that is its own negation, then a zero key that is accepted
        // only because it matches the cleared session key.
        write_client_key(32'h8000_0000);
        send_item(lkcx_pkg::OP_SET_KEY, 32'h8000_0000, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_SET_KEY, 32'h0000_0000, 8'h00, 1'b0);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'h33, 1'b1);
        send_item(lkcx_pkg::OP_ENCRYPT, '0, 8'hCC, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            phase++;
            if (!long_done && phase == 12) begin
                // One packet longer than the keystream.
                write_client_key($urandom | 32'h1);
                send_item(lkcx_pkg::OP_SET_KEY, -client_shadow, 8'($urandom), 1'($urandom));
                op = ($urandom_range(0, 1) == 0) ? lkcx_pkg::OP_ENCRYPT : lkcx_pkg::OP_DECRYPT;
                for (int i = 0; i < LONG_PACKET; i++) begin
                    send_item(op, $urandom, 8'($urandom), i == 0);
                end
                long_done = 1'b1;
            end else begin
                if (phase == 1 || $urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       write_client_key(32'h0000_0000);
                        1:       write_client_key(32'hFFFF_FFFF);
                        2:       write_client_key(32'h8000_0000);
                        default: write_client_key($urandom);
                    endcase
                end
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
                if (phase == 4) begin
                    // Sender keeps offering while the receiver stalls.
                    tx_burst = 1'b1;
                    rx_hold_req = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: key = -client_shadow;
                    4:          key = client_shadow;
                    5, 6:       key = session_shadow;
                    7:          key = 32'h0000_0000;
                    default:    key = $urandom;
                endcase
                send_item(lkcx_pkg::OP_SET_KEY, key, 8'($urandom), 1'($urandom));
                n_packets = $urandom_range(1, 4);
                repeat (n_packets) begin
                    op = ($urandom_range(0, 1) == 0) ? lkcx_pkg::OP_ENCRYPT
                                                     : lkcx_pkg::OP_DECRYPT;
                    len = $urandom_range(1, 24);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            case ($urandom_range(0, 2))
                                0: send_item(OP_UNUSED, $urandom, 8'($urandom), 1'($urandom));
                                1: send_item(lkcx_pkg::OP_SET_KEY, $urandom, 8'($urandom),
                                             1'($urandom));
                                default: send_item(op, $urandom, 8'($urandom), 1'b1);
                            endcase
                        end
                        byte_op = op;
                        if ($urandom_range(0, 7) == 0) begin
                            byte_op = (op == lkcx_pkg::OP_ENCRYPT) ? lkcx_pkg::OP_DECRYPT
                                                                   : lkcx_pkg::OP_ENCRYPT;
                        end
                        din = 8'($urandom);
                        if (i == 0 && $urandom_range(0, 2) == 0) begin
                            din = 8'h00;
                        end
                        send_item(byte_op, $urandom, din,
                                  (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
                    end
                end
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items over %0d client key writes; %0d results checked,",
                 items_sent, cfg_writes, checked);
        $display("%0d keys applied and %0d bytes past the end of the keystream.",
                 keys_applied, overruns);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/lkcx_pkg.sv
sv/lkcx_if.sv
sv/lkcx_ram.sv
sv/lkcx_ctrl.sv
sv/lkcx_datapath.sv
sv/lcg_keystream_chained_xor_cipher.sv
sv/lkcx_checker.sv
sim/lkcx_checker.sv
sim/tb_top.sv
